// ===== src/cosine_similarity_stream_assert.svh =====
// Assertion macros shared by the cosine similarity stream block.
`ifndef COSINE_SIMILARITY_STREAM_ASSERT_SVH
`define COSINE_SIMILARITY_STREAM_ASSERT_SVH
// Implication checked on every rising clock edge, disabled while reset is asserted.
`define CSS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked on every rising clock edge, disabled during reset.
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/css_pkg.sv =====
// Package with types and constants of the cosine similarity stream block.
package css_pkg;
	localparam int ElemWidth = 16;
	localparam int SumWidth = 43;
	localparam int ProdWidth = 2 * ElemWidth;
	localparam int RadWidth = SumWidth + 21;
	localparam int RootWidth = 32;
	localparam int DenWidth = 64;
	localparam int QuoBits = 36;
	localparam int RootSteps = 32;
	localparam int CntWidth = 6;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_ROOT,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} css_state_t;

	typedef struct packed {
		logic acc_en;
		logic last_in;
		logic root_start;
		logic root_step;
		logic mul_load;
		logic div_step;
		logic finish;
		logic out_load;
	} css_cmd_t;

	typedef struct packed {
		logic zero_norm;
		logic early_sat;
	} css_status_t;
endpackage

// ===== src/css_datapath.sv =====
// Datapath: accumulators, shared-step square roots, multiplier, and divider.
module css_datapath
	import css_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  css_cmd_t                     cmd,
	input  logic signed [ElemWidth-1:0]  elem_a,
	input  logic signed [ElemWidth-1:0]  elem_b,
	output css_status_t                  status,
	output logic signed [ElemWidth-1:0]  similarity,
	output logic                         zero_norm
);
	logic [SumWidth-1:0] sum_a_q, sum_b_q;
	logic signed [SumWidth-1:0] sum_c_q;
	logic [RadWidth-1:0] rad_a_q, rad_b_q;
	logic [RootWidth-1:0] root_a_q, root_b_q;
	logic [DenWidth-1:0] rem_a_q, rem_b_q;
	logic [DenWidth-1:0] den_q;
	logic [DenWidth-1:0] rem_q;
	logic [QuoBits-1:0] quo_q;
	logic neg_q;
	logic signed [ElemWidth-1:0] sim_q;
	logic zn_q;

	logic signed [ProdWidth-1:0] p_aa, p_bb, p_ab;
	logic [SumWidth+1:0] nsa, nsb;
	logic signed [SumWidth+1:0] nsc;
	logic [SumWidth-1:0] sa_sat, sb_sat;
	logic signed [SumWidth-1:0] sc_sat;
	logic [SumWidth-1:0] mag_cross;
	logic [DenWidth-1:0] rem_a_sh, rem_b_sh, trial_a, trial_b;
	logic [DenWidth-1:0] rem_sh;
	logic [QuoBits:0] mag_r;
	logic [ElemWidth:0] mag16;

	always_comb begin
		p_aa = elem_a * elem_a;
		p_bb = elem_b * elem_b;
		p_ab = elem_a * elem_b;
		nsa = {2'b0, sum_a_q} + {{(SumWidth+2-ProdWidth){1'b0}}, p_aa};
		nsb = {2'b0, sum_b_q} + {{(SumWidth+2-ProdWidth){1'b0}}, p_bb};
		nsc = {{2{sum_c_q[SumWidth-1]}}, sum_c_q} +
			{{(SumWidth+2-ProdWidth){p_ab[ProdWidth-1]}}, p_ab};
		sa_sat = nsa[SumWidth+1:SumWidth] != 2'b0 ? {SumWidth{1'b1}} : nsa[SumWidth-1:0];
		sb_sat = nsb[SumWidth+1:SumWidth] != 2'b0 ? {SumWidth{1'b1}} : nsb[SumWidth-1:0];
		if (!nsc[SumWidth+1] && nsc[SumWidth:SumWidth-1] != 2'b00)
			sc_sat = {1'b0, {(SumWidth-1){1'b1}}};
		else if (nsc[SumWidth+1] && nsc[SumWidth:SumWidth-1] != 2'b11)
			sc_sat = {1'b1, {(SumWidth-1){1'b0}}};
		else
			sc_sat = nsc[SumWidth-1:0];
		mag_cross = sum_c_q[SumWidth-1] ? SumWidth'(-sum_c_q) : sum_c_q;
		// One restoring root step: bring in two radicand bits, try 4r+1.
		rem_a_sh = {rem_a_q[DenWidth-3:0], rad_a_q[RadWidth-1:RadWidth-2]};
		rem_b_sh = {rem_b_q[DenWidth-3:0], rad_b_q[RadWidth-1:RadWidth-2]};
		trial_a = {{(DenWidth-RootWidth-2){1'b0}}, root_a_q, 2'b01};
		trial_b = {{(DenWidth-RootWidth-2){1'b0}}, root_b_q, 2'b01};
		rem_sh = {rem_q[DenWidth-2:0], 1'b0};
		mag_r = ({1'b0, quo_q} + 37'd1) >> 1;
		mag16 = mag_r > 37'd32768 ? 17'd32768 : mag_r[ElemWidth:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q <= '0;
			sum_b_q <= '0;
			sum_c_q <= '0;
		end else if (cmd.finish) begin
			sum_a_q <= '0;
			sum_b_q <= '0;
			sum_c_q <= '0;
		end else if (cmd.acc_en) begin
			sum_a_q <= sa_sat;
			sum_b_q <= sb_sat;
			sum_c_q <= sc_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.root_start) begin
			rad_a_q <= {1'b0, sum_a_q, 20'b0};
			rad_b_q <= {1'b0, sum_b_q, 20'b0};
			root_a_q <= '0;
			root_b_q <= '0;
			rem_a_q <= '0;
			rem_b_q <= '0;
			neg_q <= sum_c_q[SumWidth-1];
			rem_q <= {{(DenWidth-SumWidth){1'b0}}, mag_cross};
		end else if (cmd.root_step) begin
			rad_a_q <= {rad_a_q[RadWidth-3:0], 2'b00};
			rad_b_q <= {rad_b_q[RadWidth-3:0], 2'b00};
			if (rem_a_sh >= trial_a) begin
				rem_a_q <= rem_a_sh - trial_a;
				root_a_q <= {root_a_q[RootWidth-2:0], 1'b1};
			end else begin
				rem_a_q <= rem_a_sh;
				root_a_q <= {root_a_q[RootWidth-2:0], 1'b0};
			end
			if (rem_b_sh >= trial_b) begin
				rem_b_q <= rem_b_sh - trial_b;
				root_b_q <= {root_b_q[RootWidth-2:0], 1'b1};
			end else begin
				rem_b_q <= rem_b_sh;
				root_b_q <= {root_b_q[RootWidth-2:0], 1'b0};
			end
		end
		if (cmd.mul_load) begin
			den_q <= root_a_q * root_b_q;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_sh >= den_q) begin
				rem_q <= rem_sh - den_q;
				quo_q <= {quo_q[QuoBits-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[QuoBits-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			zn_q <= status.zero_norm;
			if (status.zero_norm)
				sim_q <= '0;
			else if (status.early_sat)
				sim_q <= neg_q ? 16'sh8000 : 16'sh7FFF;
			else if (neg_q)
				sim_q <= ElemWidth'(-$signed({1'b0, mag16}));
			else
				sim_q <= mag16 > 17'd32767 ? 16'sh7FFF : mag16[ElemWidth-1:0];
		end
	end

	assign status.zero_norm = (sum_a_q == '0) || (sum_b_q == '0);
	assign status.early_sat = rem_q >= den_q;
	assign similarity = sim_q;
	assign zero_norm = zn_q;
endmodule

// ===== src/css_ctrl.sv =====
// Controller state machine sequencing accumulate, roots, multiply, divide, output.
`include "cosine_similarity_stream_assert.svh"
module css_ctrl
	import css_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	input  css_status_t status,
	output css_cmd_t    cmd
);
	css_state_t state_q, state_d;
	logic [CntWidth-1:0] cnt_q, cnt_d;
	logic ov_q, ov_d;
	logic acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			cnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;
	assign in_stall = state_q != ST_ACC;
	assign acc = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		ov_d = ov_q && out_stall;
		cmd = '0;
		cmd.acc_en = acc;
		cmd.last_in = acc && last;
		unique case (state_q)
			ST_ACC: begin
				if (acc && last) begin
					state_d = ST_ROOT;
					cnt_d = '0;
				end
			end
			ST_ROOT: begin
				if (cnt_q == '0 && status.zero_norm) begin
					state_d = ST_OUT;
				end else if (cnt_q == '0) begin
					cmd.root_start = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end else begin
					cmd.root_step = 1'b1;
					if (cnt_q == CntWidth'(RootSteps)) begin
						state_d = ST_MUL;
						cnt_d = '0;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_d = ST_DIV;
				cnt_d = '0;
			end
			ST_DIV: begin
				if (cnt_q == '0 && status.early_sat) begin
					state_d = ST_OUT;
				end else begin
					cmd.div_step = 1'b1;
					if (cnt_q == CntWidth'(QuoBits - 1)) begin
						state_d = ST_OUT;
					end
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_OUT: begin
				if (!ov_q || !out_stall) begin
					cmd.out_load = 1'b1;
					cmd.finish = 1'b1;
					ov_d = 1'b1;
					state_d = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	`CSS_ASSERT_IMPL(a_no_acc_busy, state_q != ST_ACC, !cmd.acc_en,
		"accumulate while busy")
	`CSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid,
		"result dropped while stalled")
	`CSS_ASSERT_NEXT(a_last_to_root, cmd.last_in, state_q == ST_ROOT,
		"last request did not start the root sequence")
endmodule

// ===== src/cosine_similarity_stream.sv =====
// Top level of the cosine similarity stream block.
//
//  Channel | Signals                              | Direction
//  input   | in_valid, in_stall, elem_a, elem_b, last | into block
//  output  | out_valid, out_stall, similarity, zero_norm | out of block
//
// Element pairs are accepted one request per cycle while accumulating.
// After the last request the block stalls its input while it works: with a
// zero norm it goes straight to the output write; when the quotient saturates
// at once it skips the divide steps; otherwise it runs one load plus 32 steps
// of the two lockstep square-root units, one multiply, 36 restoring divide
// steps and one output write. The result sits in an output register, so a
// stalled output holds the next vector only once its result is ready.
// Reset clears sums and control.
`include "cosine_similarity_stream_assert.svh"
module cosine_similarity_stream
	import css_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [ElemWidth-1:0] elem_a,
	input  logic signed [ElemWidth-1:0] elem_b,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [ElemWidth-1:0] similarity,
	output logic                        zero_norm
);
	css_cmd_t cmd;
	css_status_t status;

	// The controller owns the handshakes and sequences the datapath.
	css_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.last(last), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .cmd(cmd)
	);

	// The datapath holds the sums and the iterative root and divide units.
	css_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .elem_a(elem_a), .elem_b(elem_b),
		.status(status), .similarity(similarity), .zero_norm(zero_norm)
	);

	// Within a vector the input keeps accepting requests.
	`CSS_ASSERT_NEXT(a_open_after_mid, in_valid && !in_stall && !last, !in_stall,
		"input stalled in the middle of a vector")
	`CSS_ASSERT_NEXT(a_busy_after_last, in_valid && !in_stall && last, in_stall,
		"input not stalled after last request")
	`CSS_ASSERT_IMPL(a_zero_sim, out_valid && zero_norm, similarity == '0,
		"zero norm with nonzero similarity")
endmodule

// ===== sim/cosine_similarity_checker.sv =====
// Checker that predicts cosine similarity results and compares them with the block output.
`timescale 1ns / 1ps
module cosine_similarity_checker
	import css_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic signed [ElemWidth-1:0] elem_a,
	input  logic signed [ElemWidth-1:0] elem_b,
	input  logic                        last,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic signed [ElemWidth-1:0] similarity,
	input  logic                        zero_norm,
	output int                          fail_count,
	output int                          pending,
	output int                          pairs_seen,
	output int                          cosines_seen
);
	typedef struct {
		logic signed [15:0] sim;
		logic               zn;
	} cosine_t;

	localparam longint SqMax = (64'sd1 <<< 43) - 1;
	localparam longint CrossMax = (64'sd1 <<< 42) - 1;
	localparam longint CrossMin = -CrossMax - 1;

	cosine_t cosine_q[$];
	longint energy_a, energy_b, dot_ab;

	function automatic longint clamp_add(longint acc, longint p, longint lo, longint hi);
		longint r;
		r = acc + p;
		if (r > hi) return hi;
		if (r < lo) return lo;
		return r;
	endfunction

	function automatic logic [63:0] int_root(logic [63:0] x);
		logic [63:0] res, one;
		res = 0;
		one = 64'd1 << 62;
		while (one > x) one = one >> 2;
		while (one != 0) begin
			if (x >= res + one) begin
				x = x - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	function automatic cosine_t vector_cosine(longint sa, longint sb, longint sab);
		cosine_t c;
		logic [63:0] ra, rb, den, mag_in;
		logic [127:0] quo;
		logic [31:0] mag;
		c.sim = 0;
		c.zn = 0;
		if (sa == 0 || sb == 0) begin
			c.zn = 1;
			return c;
		end
		ra = int_root(64'(sa) << 20);
		rb = int_root(64'(sb) << 20);
		den = ra * rb;
		mag_in = (sab < 0) ? 64'(-sab) : 64'(sab);
		if (mag_in >= den) begin
			mag = 32768;
		end else begin
			quo = ({64'd0, mag_in} << 36) / {64'd0, den};
			mag = 32'((quo + 1) >> 1);
			if (mag > 32768) mag = 32768;
		end
		if (sab < 0) c.sim = 16'(-mag);
		else c.sim = (mag > 32767) ? 16'sd32767 : 16'(mag);
		return c;
	endfunction

	assign pending = cosine_q.size();

	always @(posedge clk or negedge arst_n) begin
		cosine_t got, want;
		longint a, b;
		if (!arst_n) begin
			energy_a <= 0;
			energy_b <= 0;
			dot_ab <= 0;
			fail_count <= 0;
			pairs_seen <= 0;
			cosines_seen <= 0;
		end else begin
			// An accepted request folds its pair into the sums; the last one closes the vector.
			if (in_valid && !in_stall) begin
				a = elem_a;
				b = elem_b;
				pairs_seen <= pairs_seen + 1;
				if (last) begin
					cosine_q.push_back(vector_cosine(clamp_add(energy_a, a * a, 0, SqMax),
						clamp_add(energy_b, b * b, 0, SqMax),
						clamp_add(dot_ab, a * b, CrossMin, CrossMax)));
					energy_a <= 0;
					energy_b <= 0;
					dot_ab <= 0;
				end else begin
					energy_a <= clamp_add(energy_a, a * a, 0, SqMax);
					energy_b <= clamp_add(energy_b, b * b, 0, SqMax);
					dot_ab <= clamp_add(dot_ab, a * b, CrossMin, CrossMax);
				end
			end
			if (out_valid && !out_stall) begin
				cosines_seen <= cosines_seen + 1;
				if (cosine_q.size() == 0) begin
					$error("Unexpected result: similarity %0d zero_norm %0d", similarity,
						zero_norm);
					fail_count <= fail_count + 1;
				end else begin
					want = cosine_q.pop_front();
					got.sim = similarity;
					got.zn = zero_norm;
					if (got.sim !== want.sim || got.zn !== want.zn) begin
						if (got.sim !== want.sim)
							$error("similarity: expected %0d, actual %0d", want.sim, got.sim);
						if (got.zn !== want.zn)
							$error("zero_norm: expected %0d, actual %0d", want.zn, got.zn);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== sim/cosine_similarity_stream_test.sv =====
// Top of the testbench: stimulus, idling control and verdict for the cosine similarity block.
`timescale 1ns / 1ps
module cosine_similarity_stream_test;
	import css_pkg::*;

	// Worst case is at most 771 pairs, each closing a vector of its own,
	// all stretched by heavy idling, so this bound leaves wide margin.
	localparam int CycleLimit = 600000;
	localparam int DrainCycles = 150;

	logic clk = 0;
	logic arst_n;
	logic in_valid, in_stall, last, out_valid, out_stall, zero_norm;
	logic signed [ElemWidth-1:0] elem_a, elem_b, similarity;
	logic req_taken;
	int fail_count, pending, pairs_seen, cosines_seen;
	int send_idle_pct, stall_pct, cycles;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	cosine_similarity_stream i_dut (
		.clk, .arst_n, .in_valid, .in_stall, .elem_a, .elem_b, .last,
		.out_valid, .out_stall, .similarity, .zero_norm
	);

	cosine_similarity_checker i_checker (
		.clk, .arst_n, .in_valid, .in_stall, .elem_a, .elem_b, .last,
		.out_valid, .out_stall, .similarity, .zero_norm,
		.fail_count, .pending, .pairs_seen, .cosines_seen
	);

	// Remembers whether the request on the bus was taken at the last rising edge.
	always @(posedge clk) req_taken <= in_valid && !in_stall;

	// The receiver stalls at random, at a rate set per phase.
	always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Sends one pair and returns at the falling edge after it was accepted.
	task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		elem_a <= a;
		elem_b <= b;
		last <= fin;
		@(negedge clk);
		while (!req_taken) @(negedge clk);
	endtask

	// Draws one element according to the flavor of the vector.
	function automatic logic signed [15:0] pick_elem(int flavor);
		case (flavor)
			1: return 16'($signed($urandom_range(511)) - 256);
			2: begin
				case ($urandom_range(3))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return 16'sd0;
					default: return -16'sd1;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	// A random vector: mostly short, sometimes longer, with b independent, equal,
	// negated, or one side all zero.
	task automatic send_random_vector();
		int len, flavor, relation;
		logic signed [15:0] a, b;
		len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
		flavor = $urandom_range(2);
		relation = $urandom_range(9);
		for (int i = 0; i < len; i++) begin
			a = pick_elem(flavor);
			b = pick_elem(flavor);
			case (relation)
				0: b = a;
				1: b = -a;
				2: a = 0;
				3: b = 0;
				default: ;
			endcase
			send_pair(a, b, i == len - 1);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		elem_a = 0;
		elem_b = 0;
		last = 0;
		out_stall = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		cycles = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part: single-element vectors, the plus-one saturation, the most
		// negative cosine, zero norms on either side, an orthogonal pair and a short mix.
		send_pair(16'sd32767, 16'sd32767, 1);
		send_pair(-16'sd32768, -16'sd32768, 1);
		send_pair(-16'sd32768, 16'sd32767, 1);
		send_pair(16'sd32767, -16'sd32768, 1);
		send_pair(16'sd0, 16'sd1234, 1);
		send_pair(-16'sd5, 16'sd0, 1);
		send_pair(16'sd0, 16'sd0, 1);
		send_pair(16'sd1, 16'sd0, 0);
		send_pair(16'sd0, 16'sd1, 1);
		send_pair(16'sd3, 16'sd4, 0);
		send_pair(-16'sd1, 16'sd7, 0);
		send_pair(16'sd21845, -16'sd10922, 1);
		send_pair(-16'sd1, -16'sd1, 1);
		send_pair(16'sd1, 16'sd2, 0);
		send_pair(16'sd1, 16'sd2, 1);

		// The sender holds off here until every result has come back.
		wait_drained();

		// Random part in four idling phases of about 150 pairs each.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 74; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 74; end
				default: begin send_idle_pct = 30; stall_pct = 30; end
			endcase
			begin
				int start_pairs;
				start_pairs = pairs_seen;
				while (pairs_seen - start_pairs < 150) send_random_vector();
			end
			if (phase == 1) wait_drained();
		end

		in_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		$display("Run covered %0d element pairs forming %0d vectors, with directed extremes,",
			pairs_seen, cosines_seen);
		$display("zero norms, plus-one saturation and four idling phases.");
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
